// ===== rtl/assert_macros.svh =====
// Assertion macros used by the checker file of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is high.
`define DRJS_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that is also checked during reset.
`define DRJS_ASSERT_NR(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/drjs_pkg.sv =====
// Types and constants shared by the depth row jump segmenter modules.
`timescale 1ns / 1ps
package drjs_pkg;

  localparam int MAX_COLUMNS = 1024;
  localparam int COL_W       = $clog2(MAX_COLUMNS);
  localparam int MM_W        = 16;
  localparam int MAX_RES     = 4;
  localparam int IDX_W       = $clog2(MAX_RES);
  localparam int CNT_W       = $clog2(MAX_RES + 1);

  localparam logic [MM_W-1:0] THRESH_RESET = 16'd40;

  typedef logic [COL_W-1:0] col_t;
  typedef logic [MM_W-1:0]  mm_t;

  typedef enum logic [1:0] {
    EV_START   = 2'd0,
    EV_END     = 2'd1,
    EV_CLOSEST = 2'd2
  } ev_t;

  typedef struct packed {
    ev_t        event_type;
    col_t       column;
    mm_t        boundary_mm;
    logic       boundary_valid;
    col_t       closest_end_column;
    logic       closest_found;
    logic       last_result;
  } res_t;

  // All result words caused by one sample, in output order.
  typedef struct packed {
    res_t [MAX_RES-1:0] ent;
    logic [CNT_W-1:0]   cnt;
  } res_bundle_t;

endpackage

// ===== rtl/depth_row_jump_segmenter.sv =====
// A sample waits in the input register until the result buffer can take its result words.
// Throughput: one sample per cycle while out_ready is high and samples cause at most one
// word; a sample that causes more words (up to four) holds the input until all have left.
// Reset (rst, synchronous, active high) empties the input and result registers, clears
// the row state and sets the jump threshold to 40 mm.
`timescale 1ns / 1ps
module depth_row_jump_segmenter
  import drjs_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [15:0] distance_mm,
  input  logic        sample_valid,
  input  logic        row_end,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  event_type,
  output logic [9:0]  column,
  output logic [15:0] boundary_mm,
  output logic        boundary_valid,
  output logic [9:0]  closest_end_column,
  output logic        closest_found,
  output logic        last_result
);

  mm_t         jump_threshold_mm;
  logic        in_full;
  mm_t         d_q;
  logic        v_q;
  logic        end_q;
  logic        step;
  logic        can_load;
  res_bundle_t bundle;
  res_t        head;

  assign cfg_ready = 1'b1;
  assign step      = in_full && can_load;
  assign in_ready  = !in_full || step;

  always_ff @(posedge clk) begin
    if (rst) begin
      jump_threshold_mm <= THRESH_RESET;
    end else if (cfg_valid) begin
      jump_threshold_mm <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_ready) begin
      in_full <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      d_q   <= distance_mm;
      v_q   <= sample_valid;
      end_q <= row_end;
    end
  end

  drjs_seg_core u_core (
    .clk    (clk),
    .rst    (rst),
    .step   (step),
    .d      (d_q),
    .v      (v_q),
    .row_end(end_q),
    .thr    (jump_threshold_mm),
    .bundle (bundle)
  );

  drjs_out_buf u_buf (
    .clk      (clk),
    .rst      (rst),
    .load     (step),
    .bundle   (bundle),
    .out_ready(out_ready),
    .out_valid(out_valid),
    .head     (head),
    .can_load (can_load)
  );

  assign event_type         = head.event_type;
  assign column             = head.column;
  assign boundary_mm        = head.boundary_mm;
  assign boundary_valid     = head.boundary_valid;
  assign closest_end_column = head.closest_end_column;
  assign closest_found      = head.closest_found;
  assign last_result        = head.last_result;

endmodule

// ===== rtl/drjs_seg_core.sv =====
// Row segmentation state and the single-pass logic that turns one sample into result words.
`timescale 1ns / 1ps
module drjs_seg_core
  import drjs_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        step,
  input  mm_t         d,
  input  logic        v,
  input  logic        row_end,
  input  mm_t         thr,
  output res_bundle_t bundle
);

  col_t column_count, column_count_next;
  mm_t  last_valid_mm, last_valid_mm_next;
  logic last_valid_seen, last_valid_seen_next;
  mm_t  prior_raw_mm, prior_raw_mm_next;
  logic prior_raw_valid, prior_raw_valid_next;
  col_t open_start_column, open_start_column_next;
  mm_t  open_start_mm, open_start_mm_next;
  logic open_start_valid, open_start_valid_next;
  col_t best_start_column, best_start_column_next;
  col_t best_end_column, best_end_column_next;
  mm_t  best_mm, best_mm_next;
  logic best_found, best_found_next;

  logic [CNT_W-1:0] n;
  mm_t              diff;

  function automatic res_t mk_res(ev_t ev, col_t col, mm_t mm, logic valid,
                                  col_t end_col, logic found);
    res_t r;
    r.event_type         = ev;
    r.column             = col;
    r.boundary_mm        = valid ? mm : '0;
    r.boundary_valid     = valid;
    r.closest_end_column = end_col;
    r.closest_found      = found;
    r.last_result        = 1'b0;
    return r;
  endfunction

  // A closing segment replaces the best one when its start is valid, nonzero and nearer.
  function automatic logic qualifies(logic ov, mm_t omm, logic found, mm_t bmm);
    return ov && (omm != '0) && (!found || (omm < bmm));
  endfunction

  assign diff = (d >= last_valid_mm) ? (d - last_valid_mm) : (last_valid_mm - d);

  always_comb begin
    bundle                 = '0;
    n                      = '0;
    column_count_next      = column_count;
    last_valid_mm_next     = last_valid_mm;
    last_valid_seen_next   = last_valid_seen;
    prior_raw_mm_next      = prior_raw_mm;
    prior_raw_valid_next   = prior_raw_valid;
    open_start_column_next = open_start_column;
    open_start_mm_next     = open_start_mm;
    open_start_valid_next  = open_start_valid;
    best_start_column_next = best_start_column;
    best_end_column_next   = best_end_column;
    best_mm_next           = best_mm;
    best_found_next        = best_found;

    if (column_count == COL_W'(1)) begin
      bundle.ent[n[IDX_W-1:0]] = mk_res(EV_START, COL_W'(1), d, v, '0, 1'b0);
      n                        = n + CNT_W'(1);
      open_start_column_next   = COL_W'(1);
      open_start_mm_next       = d;
      open_start_valid_next    = v;
      last_valid_seen_next     = v;
      last_valid_mm_next       = v ? d : '0;
    end else if (column_count >= COL_W'(2) && v) begin
      if (last_valid_seen && (diff > thr)) begin
        bundle.ent[n[IDX_W-1:0]] = mk_res(EV_END, column_count - COL_W'(1), last_valid_mm,
                                          1'b1, '0, 1'b0);
        n = n + CNT_W'(1);
        if (qualifies(open_start_valid_next, open_start_mm_next, best_found_next,
                      best_mm_next)) begin
          best_start_column_next = open_start_column_next;
          best_end_column_next   = column_count - COL_W'(1);
          best_mm_next           = open_start_mm_next;
          best_found_next        = 1'b1;
        end
        bundle.ent[n[IDX_W-1:0]] = mk_res(EV_START, column_count, d, 1'b1, '0, 1'b0);
        n                        = n + CNT_W'(1);
        open_start_column_next   = column_count;
        open_start_mm_next       = d;
        open_start_valid_next    = 1'b1;
      end
      last_valid_mm_next   = d;
      last_valid_seen_next = 1'b1;
    end

    if (row_end) begin
      if (column_count != '0) begin
        bundle.ent[n[IDX_W-1:0]] = mk_res(EV_END, column_count - COL_W'(1), prior_raw_mm,
                                          prior_raw_valid, '0, 1'b0);
        n = n + CNT_W'(1);
        if (qualifies(open_start_valid_next, open_start_mm_next, best_found_next,
                      best_mm_next)) begin
          best_start_column_next = open_start_column_next;
          best_end_column_next   = column_count - COL_W'(1);
          best_mm_next           = open_start_mm_next;
          best_found_next        = 1'b1;
        end
      end
      if (best_found_next) begin
        bundle.ent[n[IDX_W-1:0]] = mk_res(EV_CLOSEST, best_start_column_next, best_mm_next,
                                          1'b1, best_end_column_next, 1'b1);
      end else begin
        bundle.ent[n[IDX_W-1:0]] = mk_res(EV_CLOSEST, '0, '0, 1'b0, '0, 1'b0);
      end
      n = n + CNT_W'(1);

      // The row is over: everything but the threshold returns to its reset value.
      column_count_next      = '0;
      last_valid_mm_next     = '0;
      last_valid_seen_next   = 1'b0;
      prior_raw_mm_next      = '0;
      prior_raw_valid_next   = 1'b0;
      open_start_column_next = '0;
      open_start_mm_next     = '0;
      open_start_valid_next  = 1'b0;
      best_start_column_next = '0;
      best_end_column_next   = '0;
      best_mm_next           = '1;
      best_found_next        = 1'b0;
    end else begin
      prior_raw_mm_next    = d;
      prior_raw_valid_next = v;
      if (column_count < COL_W'(MAX_COLUMNS - 1)) begin
        column_count_next = column_count + COL_W'(1);
      end
    end

    for (int i = 0; i < MAX_RES; i++) begin
      bundle.ent[i].last_result = (n != '0) && (CNT_W'(i) == (n - CNT_W'(1)));
    end
    bundle.cnt = n;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count      <= '0;
      last_valid_mm     <= '0;
      last_valid_seen   <= 1'b0;
      prior_raw_mm      <= '0;
      prior_raw_valid   <= 1'b0;
      open_start_column <= '0;
      open_start_mm     <= '0;
      open_start_valid  <= 1'b0;
      best_start_column <= '0;
      best_end_column   <= '0;
      best_mm           <= '1;
      best_found        <= 1'b0;
    end else if (step) begin
      column_count      <= column_count_next;
      last_valid_mm     <= last_valid_mm_next;
      last_valid_seen   <= last_valid_seen_next;
      prior_raw_mm      <= prior_raw_mm_next;
      prior_raw_valid   <= prior_raw_valid_next;
      open_start_column <= open_start_column_next;
      open_start_mm     <= open_start_mm_next;
      open_start_valid  <= open_start_valid_next;
      best_start_column <= best_start_column_next;
      best_end_column   <= best_end_column_next;
      best_mm           <= best_mm_next;
      best_found        <= best_found_next;
    end
  end

endmodule

// ===== rtl/drjs_out_buf.sv =====
// Result buffer that holds the words of one sample and hands them out one per cycle while out_ready is high.
`timescale 1ns / 1ps
module drjs_out_buf
  import drjs_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        load,
  input  res_bundle_t bundle,
  input  logic        out_ready,
  output logic        out_valid,
  output res_t        head,
  output logic        can_load
);

  res_t [MAX_RES-1:0] ent;
  logic [CNT_W-1:0]   cnt;
  logic               pop;

  assign out_valid = (cnt != '0);
  assign pop       = out_valid && out_ready;
  assign head      = ent[0];
  // A new batch may enter once the buffer is empty or its last word leaves now.
  assign can_load  = (cnt == '0) || ((cnt == CNT_W'(1)) && out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (load) begin
      cnt <= bundle.cnt;
    end else if (pop) begin
      cnt <= cnt - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      ent <= bundle.ent;
    end else if (pop) begin
      for (int i = 0; i < MAX_RES - 1; i++) begin
        ent[i] <= ent[i + 1];
      end
    end
  end

endmodule

// ===== rtl/drjs_checker.sv =====
// Port-level checks for the depth row jump segmenter and the bind that attaches them.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module drjs_checker
  import drjs_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        cfg_valid,
  input logic        cfg_ready,
  input logic [15:0] cfg_data,
  input logic        in_valid,
  input logic        in_ready,
  input logic [15:0] distance_mm,
  input logic        sample_valid,
  input logic        row_end,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  event_type,
  input logic [9:0]  column,
  input logic [15:0] boundary_mm,
  input logic        boundary_valid,
  input logic [9:0]  closest_end_column,
  input logic        closest_found,
  input logic        last_result
);

  `DRJS_ASSERT_NR(a_reset_empties, clk, rst |=> !out_valid, "output word present after reset")
  `DRJS_ASSERT(a_out_hold, clk, rst, out_valid && !out_ready |=> out_valid, "output word dropped")
  `DRJS_ASSERT(a_report_last, clk, rst, out_valid && event_type == EV_CLOSEST |-> last_result, "closest report is not the final word")
  `DRJS_ASSERT(a_boundary_zero, clk, rst, out_valid && !boundary_valid |-> boundary_mm == 16'd0, "invalid boundary carries a distance")
  `DRJS_ASSERT(a_found_only_report, clk, rst, out_valid && event_type != EV_CLOSEST |-> !closest_found && closest_end_column == 10'd0, "closest fields set on a boundary word")

endmodule

bind depth_row_jump_segmenter drjs_checker u_drjs_checker (.*);

// ===== dv/depth_row_jump_segmenter_test.sv =====
// Self-checking testbench for the depth row jump segmenter with a built-in row predictor.
`timescale 1ns / 1ps
module depth_row_jump_segmenter_test;
  import drjs_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 8;

  typedef struct {
    mm_t  depth;
    logic ok;
    logic last;
  } sample_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [15:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [15:0] distance_mm = '0;
  logic        sample_valid = 1'b0;
  logic        row_end = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  event_type;
  logic [9:0]  column;
  logic [15:0] boundary_mm;
  logic        boundary_valid;
  logic [9:0]  closest_end_column;
  logic        closest_found;
  logic        last_result;

  depth_row_jump_segmenter u_dut (
    .clk                (clk),
    .rst                (rst),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_data           (cfg_data),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .distance_mm        (distance_mm),
    .sample_valid       (sample_valid),
    .row_end            (row_end),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .event_type         (event_type),
    .column             (column),
    .boundary_mm        (boundary_mm),
    .boundary_valid     (boundary_valid),
    .closest_end_column (closest_end_column),
    .closest_found      (closest_found),
    .last_result        (last_result)
  );

  always #5 clk = ~clk;

  sample_t pending_samples[$];
  res_t    expected_words[$];

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int send_burst = 0;
  int recv_burst = 0;
  int mismatches = 0;
  int samples_sent = 0;
  int rows_done = 0;
  int words_checked = 0;
  int settings_used = 0;
  int cycle_count = 0;

  // Predictor copy of the row state and the threshold.
  mm_t  threshold = THRESH_RESET;
  int   row_col;
  mm_t  last_mm;
  logic last_seen;
  mm_t  prior_mm;
  logic prior_ok;
  int   open_col;
  mm_t  open_mm;
  logic open_ok;
  int   best_col;
  int   best_end;
  mm_t  best_mm;
  logic best_ok;

  task automatic clear_row_state();
    row_col   = 0;
    last_mm   = '0;
    last_seen = 1'b0;
    prior_mm  = '0;
    prior_ok  = 1'b0;
    open_col  = 0;
    open_mm   = '0;
    open_ok   = 1'b0;
    best_col  = 0;
    best_end  = 0;
    best_mm   = '1;
    best_ok   = 1'b0;
  endtask

  function automatic res_t make_word(ev_t ev, int col, mm_t mm, logic ok, int end_col,
                                     logic found);
    res_t w;
    w.event_type         = ev;
    w.column             = col_t'(col);
    w.boundary_mm        = ok ? mm : '0;
    w.boundary_valid     = ok;
    w.closest_end_column = col_t'(end_col);
    w.closest_found      = found;
    w.last_result        = 1'b0;
    return w;
  endfunction

  task automatic close_open_segment(input int end_col);
    if (open_ok && open_mm > 0 && (!best_ok || open_mm < best_mm)) begin
      best_col = open_col;
      best_end = end_col;
      best_mm  = open_mm;
      best_ok  = 1'b1;
    end
  endtask

  // Works out the result words one accepted sample causes and queues them.
  task automatic segment_row_sample(input mm_t d, input logic ok, input logic last);
    res_t words[MAX_RES];
    int   n;
    int   c;
    mm_t  diff;
    n = 0;
    c = row_col;
    if (c == 1) begin
      words[n++] = make_word(EV_START, 1, d, ok, 0, 1'b0);
      open_col  = 1;
      open_mm   = d;
      open_ok   = ok;
      last_seen = ok;
      last_mm   = ok ? d : '0;
    end else if (c >= 2 && ok) begin
      if (last_seen) begin
        diff = (d > last_mm) ? d - last_mm : last_mm - d;
        if (diff > threshold) begin
          words[n++] = make_word(EV_END, c - 1, last_mm, 1'b1, 0, 1'b0);
          close_open_segment(c - 1);
          words[n++] = make_word(EV_START, c, d, 1'b1, 0, 1'b0);
          open_col = c;
          open_mm  = d;
          open_ok  = 1'b1;
        end
      end
      last_mm   = d;
      last_seen = 1'b1;
    end
    if (last) begin
      if (c >= 1) begin
        words[n++] = make_word(EV_END, c - 1, prior_mm, prior_ok, 0, 1'b0);
        close_open_segment(c - 1);
      end
      if (best_ok)
        words[n++] = make_word(EV_CLOSEST, best_col, best_mm, 1'b1, best_end, 1'b1);
      else
        words[n++] = make_word(EV_CLOSEST, 0, '0, 1'b0, 0, 1'b0);
      clear_row_state();
      rows_done++;
    end else begin
      prior_mm = d;
      prior_ok = ok;
      if (row_col < MAX_COLUMNS - 1)
        row_col++;
    end
    for (int k = 0; k < n; k++) begin
      if (k == n - 1)
        words[k].last_result = 1'b1;
      expected_words.insert(expected_words.size(), words[k]);
    end
  endtask

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (got !== want) begin
      mismatches++;
      if (mismatches <= 40)
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    end
  endtask

  // Sample driver: a slot frees up when the current sample is taken or none is offered.
  always @(posedge clk) begin
    sample_t nxt;
    logic    offer;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        segment_row_sample(distance_mm, sample_valid, row_end);
        samples_sent++;
      end
      if (!in_valid || in_ready) begin
        if (send_burst > 0)
          send_burst--;
        else if ($urandom_range(0, 99) < 2)
          send_burst = 30;
        offer = (send_burst > 0) || ($urandom_range(0, 99) >= send_idle_pct);
        if (pending_samples.size() > 0 && offer) begin
          nxt = pending_samples.pop_front();
          in_valid     <= 1'b1;
          distance_mm  <= nxt.depth;
          sample_valid <= nxt.ok;
          row_end      <= nxt.last;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor.
  always @(posedge clk) begin
    res_t want;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_words.size() == 0) begin
          mismatches++;
          if (mismatches <= 40)
            $display("%0t: unexpected word, expected none, actual type %0d column %0d",
                     $time, event_type, column);
        end else begin
          want = expected_words.pop_front();
          check_field("event_type", 16'(want.event_type), 16'(event_type));
          check_field("column", 16'(want.column), 16'(column));
          check_field("boundary_mm", want.boundary_mm, boundary_mm);
          check_field("boundary_valid", 16'(want.boundary_valid), 16'(boundary_valid));
          check_field("closest_end_column", 16'(want.closest_end_column),
                      16'(closest_end_column));
          check_field("closest_found", 16'(want.closest_found), 16'(closest_found));
          check_field("last_result", 16'(want.last_result), 16'(last_result));
          words_checked++;
        end
      end
      if (recv_burst > 0)
        recv_burst--;
      else if ($urandom_range(0, 99) < 2)
        recv_burst = 30;
      out_ready <= (recv_burst > 0) || ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d words outstanding.", cycle_count,
               expected_words.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic queue_sample(input mm_t d, input logic ok, input logic last);
    sample_t s;
    s.depth = d;
    s.ok    = ok;
    s.last  = last;
    pending_samples.insert(pending_samples.size(), s);
  endtask

  // A well-formed row: a drifting distance with occasional steps and dropouts.
  task automatic queue_row(input int len);
    int base;
    int step;
    base = $urandom_range(0, 65535);
    for (int i = 0; i <= len; i++) begin
      if ($urandom_range(0, 99) < 20) begin
        base = $urandom_range(0, 65535);
      end else begin
        step = $urandom_range(0, 60);
        base = base + step - 30;
        if (base < 0)
          base = 0;
        if (base > 65535)
          base = 65535;
      end
      queue_sample(mm_t'(base), $urandom_range(0, 99) < 85, i == len);
    end
  endtask

  task automatic queue_random_items(input int count);
    int added;
    int len;
    added = 0;
    while (added < count) begin
      if ($urandom_range(0, 99) < 80) begin
        len = $urandom_range(0, 12);
        queue_row(len);
        added += len + 1;
      end else begin
        queue_sample(mm_t'($urandom_range(0, 65535)), 1'($urandom_range(0, 1)),
                     $urandom_range(0, 9) == 0);
        added++;
      end
    end
  endtask

  // Waits until every sample has gone in and every word has come out.
  task automatic wait_drained();
    do @(negedge clk);
    while (pending_samples.size() > 0 || in_valid || expected_words.size() > 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_threshold(input mm_t value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk);
    while (!cfg_ready);
    threshold = value;
    cfg_valid <= 1'b0;
    settings_used++;
  endtask

  task automatic run_phase(input mm_t thr, input int snd_pct, input int rcv_pct,
                           input int count);
    wait_drained();
    write_threshold(thr);
    @(negedge clk);
    send_idle_pct = snd_pct;
    recv_idle_pct = rcv_pct;
    queue_random_items(count / 2);
    // The sender holds off here until the block has caught up.
    wait_drained();
    queue_random_items(count - count / 2);
  endtask

  initial begin
    clear_row_state();
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    write_threshold(16'd40);
    @(negedge clk);
    send_idle_pct = 29;
    recv_idle_pct = 81;
    // Row that ends on column zero: only the report.
    queue_sample(16'd100, 1'b1, 1'b1);
    // Row that ends on column one.
    queue_sample(16'd500, 1'b1, 1'b0);
    queue_sample(16'd600, 1'b1, 1'b1);
    // Row that ends on column one with invalid samples.
    queue_sample(16'd9, 1'b0, 1'b0);
    queue_sample(16'd20, 1'b0, 1'b1);
    // Invalid seed, a skipped invalid sample and a jump on the last sample.
    queue_sample(16'd0, 1'b1, 1'b0);
    queue_sample(16'd0, 1'b0, 1'b0);
    queue_sample(16'd1000, 1'b1, 1'b0);
    queue_sample(16'd2000, 1'b1, 1'b0);
    queue_sample(16'hFFFF, 1'b0, 1'b0);
    queue_sample(16'd2010, 1'b1, 1'b0);
    queue_sample(16'hFFFF, 1'b1, 1'b1);
    // Zero start distance, a tie for closest and an invalid sample before the end.
    queue_sample(16'd7, 1'b1, 1'b0);
    queue_sample(16'd0, 1'b1, 1'b0);
    queue_sample(16'd300, 1'b1, 1'b0);
    queue_sample(16'd300, 1'b1, 1'b0);
    queue_sample(16'd900, 1'b1, 1'b0);
    queue_sample(16'd300, 1'b1, 1'b0);
    queue_sample(16'hFFFF, 1'b1, 1'b0);
    queue_sample(16'd5, 1'b0, 1'b0);
    queue_sample(16'd10, 1'b1, 1'b1);
    queue_random_items(20);

    run_phase(16'd0, 29, 81, 60);
    run_phase(16'hFFFF, 81, 29, 60);
    run_phase(mm_t'($urandom_range(0, 65535)), 81, 29, 60);
    run_phase(mm_t'($urandom_range(1, 200)), 0, 0, 60);

    wait_drained();
    if (expected_words.size() > 0) begin
      mismatches++;
      $display("%0t: %0d expected words never arrived", $time, expected_words.size());
    end
    $display("Summary: %0d samples in %0d rows under %0d threshold settings,", samples_sent,
             rows_done, settings_used);
    $display("  %0d result words checked, %0d mismatches.", words_checked, mismatches);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== depth_row_jump_segmenter.f =====
+incdir+rtl
rtl/drjs_pkg.sv
rtl/drjs_seg_core.sv
rtl/drjs_out_buf.sv
rtl/depth_row_jump_segmenter.sv
rtl/drjs_checker.sv
dv/depth_row_jump_segmenter_test.sv
